>>> src/fcrct_pkg.sv
package fcrct_pkg;

    typedef enum logic [2:0] {
        FN_TICK      = 3'd0,
        FN_RD_COUNT  = 3'd1,
        FN_RD_MODE   = 3'd2,
        FN_RD_TARGET = 3'd3,
        FN_WR_COUNT  = 3'd4,
        FN_WR_MODE   = 3'd5,
        FN_WR_TARGET = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        CFG_PIXEL  = 2'd0,
        CFG_HBLANK = 2'd1,
        CFG_VBLANK = 2'd2
    } t_cfg_reg;

    localparam int CFG_W  = 20;
    localparam int DATA_W = 16;
    localparam int IRQ_W  = 8;
    localparam int VBLANK_IDX = 3;

    localparam logic [CFG_W-1:0] PIXEL_DIV_RST  = 20'd5;
    localparam logic [CFG_W-1:0] HBLANK_DIV_RST = 20'd2154;
    localparam logic [CFG_W-1:0] VBLANK_DIV_RST = 20'd564480;
    localparam logic [3:0]       DIV8           = 4'd8;

    localparam logic [DATA_W-1:0] M_COUNT_TO_TARGET = 16'h0008;
    localparam logic [DATA_W-1:0] M_IRQ_ON_TARGET   = 16'h0010;
    localparam logic [DATA_W-1:0] M_IRQ_ON_MAX      = 16'h0020;
    localparam logic [DATA_W-1:0] M_IRQ_REPEAT      = 16'h0040;
    localparam logic [DATA_W-1:0] M_SRC_MASK        = 16'h0300;
    localparam logic [DATA_W-1:0] M_SRC_PIXEL       = 16'h0100;
    localparam logic [DATA_W-1:0] M_SRC_DIV8        = 16'h0200;
    localparam logic [DATA_W-1:0] M_IRQ_REQUEST     = 16'h0400;
    localparam logic [DATA_W-1:0] M_REACHED_TARGET  = 16'h0800;
    localparam logic [DATA_W-1:0] M_REACHED_MAX     = 16'h1000;
    localparam logic [DATA_W-1:0] VBLANK_MODE_RST   = 16'h0808;

    // bits that any counter can drive on the interrupt lines
    localparam logic [IRQ_W-1:0] IRQ_USED_MASK = 8'h71;

    function automatic logic [IRQ_W-1:0] irq_code(input int unsigned idx);
        logic [IRQ_W-1:0] code;
        unique case (idx)
            0:       code = 8'h10;
            1:       code = 8'h20;
            2:       code = 8'h40;
            3:       code = 8'h01;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

>>> src/four_channel_root_counter_timer.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | i_in_valid / o_in_ready  | i_func, i_counter_index, i_value
// out     | output    | o_out_valid / i_out_ready| o_read_data, o_irq_lines
// cfg     | input     | psel, penable, pwrite    | paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while the output is not stalled. Each item is held in the input register and
// is then resolved in a single pass (prescaler add/compare, count update, event check)
// into the output register.
// Reset is synchronous, active low, and loads the power-up timer state at once.
// A stalled output holds its result; the input register still takes one more item.
module four_channel_root_counter_timer
    import fcrct_pkg::*;
#(
    parameter int NUM_COUNTERS   = 4,
    parameter int COUNT_WIDTH    = 16,
    parameter int PRESCALE_WIDTH = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_func,
    input  logic [1:0]          i_counter_index,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [DATA_W-1:0]   o_read_data,
    output logic [IRQ_W-1:0]    o_irq_lines,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // configuration
    logic [CFG_W-1:0] r_pixel_div, r_hblank_div, r_vblank_div;
    logic             w_cfg_wr;
    t_cfg_reg         w_cfg_idx;

    // input stage
    logic              r_in_valid;
    t_func             r_func;
    logic [1:0]        r_idx;
    logic [DATA_W-1:0] r_value;
    logic              w_adv;

    // timer state
    logic [COUNT_WIDTH-1:0]    r_cnt   [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0]    r_tgt   [NUM_COUNTERS];
    logic [DATA_W-1:0]         r_mode  [NUM_COUNTERS];
    logic [PRESCALE_WIDTH-1:0] r_phase [NUM_COUNTERS];
    logic [PRESCALE_WIDTH-1:0] r_div   [NUM_COUNTERS];
    logic                      r_head  [NUM_COUNTERS];

    logic [COUNT_WIDTH-1:0]    n_cnt   [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0]    n_tgt   [NUM_COUNTERS];
    logic [DATA_W-1:0]         n_mode  [NUM_COUNTERS];
    logic [PRESCALE_WIDTH-1:0] n_phase [NUM_COUNTERS];
    logic [PRESCALE_WIDTH-1:0] n_div   [NUM_COUNTERS];
    logic                      n_head  [NUM_COUNTERS];

    // values after tick or write, before the event check
    logic [COUNT_WIDTH-1:0]    w_cnt_a  [NUM_COUNTERS];
    logic [DATA_W-1:0]         w_mode_a [NUM_COUNTERS];
    logic                      w_head_a [NUM_COUNTERS];
    logic                      w_chk    [NUM_COUNTERS];
    logic [PRESCALE_WIDTH:0]   w_inc    [NUM_COUNTERS];

    logic [DATA_W-1:0] n_read_data;
    logic [IRQ_W-1:0]  n_irq;

    // output stage
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic [IRQ_W-1:0]  r_irq;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_cfg_reg'(paddr[3:2]);

    always_comb begin
        unique case (w_cfg_idx)
            CFG_PIXEL:  prdata = 32'(r_pixel_div);
            CFG_HBLANK: prdata = 32'(r_hblank_div);
            CFG_VBLANK: prdata = 32'(r_vblank_div);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_div  <= PIXEL_DIV_RST;
            r_hblank_div <= HBLANK_DIV_RST;
            r_vblank_div <= VBLANK_DIV_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                CFG_PIXEL:  r_pixel_div  <= pwdata[CFG_W-1:0];
                CFG_HBLANK: r_hblank_div <= pwdata[CFG_W-1:0];
                CFG_VBLANK: r_vblank_div <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_lines = r_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func  <= t_func'(i_func);
            r_idx   <= i_counter_index;
            r_value <= i_value;
        end
    end

    // ---------------- single-pass update ----------------
    always_comb begin
        n_read_data = '0;
        n_irq       = '0;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            w_inc[i]    = {1'b0, r_phase[i]} + 1'b1;
            w_cnt_a[i]  = r_cnt[i];
            w_mode_a[i] = r_mode[i];
            w_head_a[i] = r_head[i];
            w_chk[i]    = 1'b0;
            n_tgt[i]    = r_tgt[i];
            n_phase[i]  = r_phase[i];
            n_div[i]    = r_div[i];

            if (r_func == FN_TICK) begin
                if (w_inc[i] >= {1'b0, r_div[i]}) begin
                    n_phase[i] = '0;
                    w_cnt_a[i] = r_cnt[i] + 1'b1;
                    w_chk[i]   = 1'b1;
                end else begin
                    n_phase[i] = w_inc[i][PRESCALE_WIDTH-1:0];
                end
            end else if (int'(r_idx) == i) begin
                unique case (r_func)
                    FN_WR_COUNT: begin
                        w_cnt_a[i]  = COUNT_WIDTH'(r_value);
                        n_phase[i]  = '0;
                        w_head_a[i] = COUNT_WIDTH'(r_value) < r_tgt[i];
                        w_chk[i]    = 1'b1;
                    end
                    FN_WR_MODE: begin
                        w_mode_a[i] = r_value;
                        w_cnt_a[i]  = '0;
                        n_phase[i]  = '0;
                        w_head_a[i] = r_tgt[i] != '0;
                        w_chk[i]    = 1'b1;
                        // divider source is latched with the mode word
                        if (i == 0) begin
                            n_div[i] = ((r_value & M_SRC_MASK) == M_SRC_PIXEL)
                                     ? PRESCALE_WIDTH'(r_pixel_div) : PRESCALE_WIDTH'(1);
                        end else if (i == 1) begin
                            n_div[i] = ((r_value & M_SRC_MASK) == M_SRC_PIXEL)
                                     ? PRESCALE_WIDTH'(r_hblank_div) : PRESCALE_WIDTH'(1);
                        end else if (i == 2) begin
                            n_div[i] = ((r_value & M_SRC_MASK) == M_SRC_DIV8)
                                     ? PRESCALE_WIDTH'(DIV8) : PRESCALE_WIDTH'(1);
                        end else if (i == VBLANK_IDX) begin
                            n_div[i] = PRESCALE_WIDTH'(r_vblank_div);
                        end else begin
                            n_div[i] = PRESCALE_WIDTH'(1);
                        end
                    end
                    FN_WR_TARGET: begin
                        n_tgt[i]    = COUNT_WIDTH'(r_value);
                        n_phase[i]  = '0;
                        w_head_a[i] = r_cnt[i] < COUNT_WIDTH'(r_value);
                        w_chk[i]    = 1'b1;
                    end
                    FN_RD_COUNT:  n_read_data = DATA_W'(r_cnt[i]);
                    FN_RD_MODE:   n_read_data = r_mode[i];
                    FN_RD_TARGET: n_read_data = DATA_W'(r_tgt[i]);
                    default: ;
                endcase
            end

            // target / maximum event
            n_cnt[i]  = w_cnt_a[i];
            n_mode[i] = w_mode_a[i];
            n_head[i] = w_head_a[i];
            if (w_chk[i] && w_head_a[i] && w_cnt_a[i] == n_tgt[i]) begin
                if ((w_mode_a[i] & M_COUNT_TO_TARGET) != '0) begin
                    n_cnt[i]  = '0;
                    n_head[i] = n_tgt[i] != '0;
                end else begin
                    n_head[i] = 1'b0;
                end
                if ((w_mode_a[i] & M_IRQ_ON_TARGET) != '0 &&
                    ((w_mode_a[i] & M_IRQ_REPEAT) != '0 ||
                     (w_mode_a[i] & M_REACHED_TARGET) == '0)) begin
                    n_irq = n_irq | irq_code(i);
                end
                n_mode[i] = w_mode_a[i] | M_REACHED_TARGET | M_IRQ_REQUEST;
            end else if (w_chk[i] && !w_head_a[i] && w_cnt_a[i] == CNT_MAX) begin
                n_cnt[i]  = '0;
                n_head[i] = n_tgt[i] != '0;
                if ((w_mode_a[i] & M_IRQ_ON_MAX) != '0 &&
                    ((w_mode_a[i] & M_IRQ_REPEAT) != '0 ||
                     (w_mode_a[i] & M_REACHED_MAX) == '0)) begin
                    n_irq = n_irq | irq_code(i);
                end
                n_mode[i] = w_mode_a[i] | M_REACHED_MAX | M_IRQ_REQUEST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_cnt[i]   <= '0;
                r_phase[i] <= '0;
                if (i == VBLANK_IDX) begin
                    r_tgt[i]  <= COUNT_WIDTH'(1);
                    r_mode[i] <= VBLANK_MODE_RST;
                    r_div[i]  <= PRESCALE_WIDTH'(VBLANK_DIV_RST);
                    r_head[i] <= 1'b1;
                end else begin
                    r_tgt[i]  <= '0;
                    r_mode[i] <= '0;
                    r_div[i]  <= PRESCALE_WIDTH'(1);
                    r_head[i] <= 1'b0;
                end
            end
        end else begin
            if (r_in_valid && w_adv) begin
                for (int i = 0; i < NUM_COUNTERS; i++) begin
                    r_cnt[i]   <= n_cnt[i];
                    r_tgt[i]   <= n_tgt[i];
                    r_mode[i]  <= n_mode[i];
                    r_phase[i] <= n_phase[i];
                    r_div[i]   <= n_div[i];
                    r_head[i]  <= n_head[i];
                end
            end
            // vblank rate applies to its counter immediately
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                if (i == VBLANK_IDX && w_cfg_wr && w_cfg_idx == CFG_VBLANK) begin
                    r_div[i] <= PRESCALE_WIDTH'(pwdata[CFG_W-1:0]);
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_read_data <= n_read_data;
            r_irq       <= n_irq;
        end
    end

`ifndef SYNTHESIS
    a_empty_out_takes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled while output register empty");

    a_irq_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq_lines != '0) |-> (o_read_data == '0))
        else $error("read data alongside an interrupt");

    a_irq_known_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_irq_lines & ~IRQ_USED_MASK) == '0))
        else $error("interrupt on an unused line");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import fcrct_pkg::*;

    localparam int NUM_TIMERS   = 4;
    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 64;
    localparam logic [CFG_W-1:0]  DIV_MAX   = 20'hfffff;
    localparam logic [DATA_W-1:0] COUNT_MAX = 16'hffff;
    // interrupt line of each timer, timer 0 in the low byte
    localparam logic [31:0] TIMER_IRQ = 32'h01_40_20_10;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [IRQ_W-1:0]  irq;
    } timer_reply_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [2:0]          i_func;
    logic [1:0]          i_counter_index;
    logic [DATA_W-1:0]   i_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [DATA_W-1:0]   o_read_data;
    logic [IRQ_W-1:0]    o_irq_lines;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predicted timer state
    logic [DATA_W-1:0] tm_count  [NUM_TIMERS];
    logic [DATA_W-1:0] tm_target [NUM_TIMERS];
    logic [DATA_W-1:0] tm_mode   [NUM_TIMERS];
    logic [CFG_W-1:0]  tm_phase  [NUM_TIMERS];
    logic [CFG_W-1:0]  tm_div    [NUM_TIMERS];
    logic              tm_armed  [NUM_TIMERS];
    logic [CFG_W-1:0]  pixel_div;
    logic [CFG_W-1:0]  hblank_div;
    logic [CFG_W-1:0]  vblank_div;

    timer_reply_t expected_replies[$];
    timer_reply_t want;

    int  errors          = 0;
    int  cycle_count     = 0;
    int  items_sent      = 0;
    int  ticks_sent      = 0;
    int  replies_checked = 0;
    int  irq_replies     = 0;
    int  cfg_writes      = 0;
    bit  idle_bursts     = 1'b1;
    bit  long_hold_req   = 1'b0;

    four_channel_root_counter_timer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_counter_index (i_counter_index),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_irq_lines     (o_irq_lines),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, expected_replies.size());
        $display("four_channel_root_counter_timer regression: fail");
        $finish;
    end

    // ---------------- timer predictor ----------------

    function automatic void reset_timers();
        pixel_div  = PIXEL_DIV_RST;
        hblank_div = HBLANK_DIV_RST;
        vblank_div = VBLANK_DIV_RST;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tm_count[i]  = '0;
            tm_target[i] = '0;
            tm_mode[i]   = '0;
            tm_phase[i]  = '0;
            tm_div[i]    = 20'd1;
            tm_armed[i]  = 1'b0;
        end
        tm_target[VBLANK_IDX] = 16'd1;
        tm_mode[VBLANK_IDX]   = VBLANK_MODE_RST;
        tm_div[VBLANK_IDX]    = vblank_div;
        tm_armed[VBLANK_IDX]  = 1'b1;
    endfunction

    // target or wrap event of one timer; returns its interrupt line if raised
    function automatic logic [IRQ_W-1:0] settle_timer(int i);
        logic [DATA_W-1:0] m;
        logic              raise;
        m = tm_mode[i];
        raise = 1'b0;
        if (tm_armed[i] && tm_count[i] == tm_target[i]) begin
            if ((m & M_COUNT_TO_TARGET) != 0)
                tm_count[i] = '0;
            tm_armed[i] = tm_count[i] < tm_target[i];
            raise = (m & M_IRQ_ON_TARGET) != 0 &&
                    ((m & M_IRQ_REPEAT) != 0 || (m & M_REACHED_TARGET) == 0);
            tm_mode[i] = m | M_REACHED_TARGET | M_IRQ_REQUEST;
        end else if (!tm_armed[i] && tm_count[i] == COUNT_MAX) begin
            tm_count[i] = '0;
            tm_armed[i] = tm_count[i] < tm_target[i];
            raise = (m & M_IRQ_ON_MAX) != 0 &&
                    ((m & M_IRQ_REPEAT) != 0 || (m & M_REACHED_MAX) == 0);
            tm_mode[i] = m | M_REACHED_MAX | M_IRQ_REQUEST;
        end
        return raise ? TIMER_IRQ[8*i +: 8] : '0;
    endfunction

    function automatic logic [CFG_W-1:0] divider_for(int i, logic [DATA_W-1:0] mode);
        logic [DATA_W-1:0] src;
        src = mode & M_SRC_MASK;
        case (i)
            0:       return (src == M_SRC_PIXEL) ? pixel_div : 20'd1;
            1:       return (src == M_SRC_PIXEL) ? hblank_div : 20'd1;
            2:       return (src == M_SRC_DIV8) ? CFG_W'(DIV8) : 20'd1;
            default: return vblank_div;
        endcase
    endfunction

    function automatic timer_reply_t timer_result(t_func f, int idx, logic [DATA_W-1:0] v);
        timer_reply_t r;
        r = '0;
        case (f)
            FN_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    // a phase whose next value reaches or passes the divider counts on this tick
                    if (32'(tm_phase[i]) + 32'd1 >= 32'(tm_div[i])) begin
                        tm_phase[i] = '0;
                        tm_count[i] = tm_count[i] + 1'b1;
                        r.irq |= settle_timer(i);
                    end else begin
                        tm_phase[i] = tm_phase[i] + 1'b1;
                    end
                end
            end
            FN_RD_COUNT:  r.data = tm_count[idx];
            FN_RD_MODE:   r.data = tm_mode[idx];
            FN_RD_TARGET: r.data = tm_target[idx];
            FN_WR_COUNT: begin
                tm_count[idx] = v;
                tm_phase[idx] = '0;
                tm_armed[idx] = tm_count[idx] < tm_target[idx];
                r.irq = settle_timer(idx);
            end
            FN_WR_MODE: begin
                tm_mode[idx]  = v;
                tm_div[idx]   = divider_for(idx, v);
                tm_count[idx] = '0;
                tm_phase[idx] = '0;
                tm_armed[idx] = tm_count[idx] < tm_target[idx];
                r.irq = settle_timer(idx);
            end
            FN_WR_TARGET: begin
                tm_target[idx] = v;
                tm_phase[idx]  = '0;
                tm_armed[idx]  = tm_count[idx] < tm_target[idx];
                r.irq = settle_timer(idx);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: result with no item pending: expected none, actual %h/%h",
                         $time, o_read_data, o_irq_lines);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (o_read_data !== want.data) begin
                    $display("%0t: read_data mismatch: expected %h, actual %h",
                             $time, want.data, o_read_data);
                    errors++;
                end
                if (o_irq_lines !== want.irq) begin
                    $display("%0t: irq_lines mismatch: expected %h, actual %h",
                             $time, want.irq, o_irq_lines);
                    errors++;
                end
                replies_checked++;
                if (want.irq != '0)
                    irq_replies++;
            end
        end
    end

    // ---------------- result receiver ----------------

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------- item and register drivers ----------------

    task automatic send_item(t_func f, logic [1:0] idx, logic [DATA_W-1:0] v);
        if (idle_bursts && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_counter_index <= idx;
        i_value         <= v;
        do @(posedge i_clk); while (!o_in_ready);
        expected_replies.push_back(timer_result(f, int'(idx), v));
        items_sent++;
        if (f == FN_TICK)
            ticks_sent++;
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_divider(t_cfg_reg r, logic [CFG_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= 32'(d);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            CFG_PIXEL:  pixel_div = d;
            CFG_HBLANK: hblank_div = d;
            CFG_VBLANK: begin
                vblank_div = d;
                tm_div[VBLANK_IDX] = d;    // timer 3 follows at once
            end
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_dividers(logic [CFG_W-1:0] pix, logic [CFG_W-1:0] hbl,
                                logic [CFG_W-1:0] vbl);
        wait_for_replies();
        write_divider(CFG_PIXEL, pix);
        write_divider(CFG_HBLANK, hbl);
        write_divider(CFG_VBLANK, vbl);
    endtask

    // ---------------- stimulus ----------------

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, 20));
            1:       return 16'($urandom_range(16'hffe0, 16'hffff));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_noise_item();
        send_item(t_func'($urandom_range(0, 6)), 2'($urandom_range(0, 3)), pick_value());
    endtask

    // program one timer, then tick it toward its target with a few reads mixed in
    task automatic send_timer_sequence();
        logic [1:0]        idx;
        logic [DATA_W-1:0] mode;
        logic [DATA_W-1:0] tgt;
        logic [DATA_W-1:0] start_count;
        int                n_ticks;
        idx  = 2'($urandom_range(0, 3));
        mode = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            mode &= M_COUNT_TO_TARGET | M_IRQ_ON_TARGET | M_IRQ_ON_MAX | M_IRQ_REPEAT |
                    M_SRC_MASK;
        case ($urandom_range(0, 3))
            0:       tgt = '0;
            1:       tgt = 16'($urandom_range(16'hfff0, 16'hffff));
            default: tgt = 16'($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 1) == 0)
            start_count = tgt - 16'($urandom_range(0, 3));
        else
            start_count = 16'($urandom_range(16'hfff8, 16'hffff));
        send_item(FN_WR_MODE, idx, mode);
        send_item(FN_WR_TARGET, idx, tgt);
        if ($urandom_range(0, 1) == 0)
            send_item(FN_WR_COUNT, idx, start_count);
        n_ticks = $urandom_range(4, 30);
        repeat (n_ticks) begin
            if ($urandom_range(0, 5) == 0)
                send_item(t_func'($urandom_range(FN_RD_COUNT, FN_RD_TARGET)), idx,
                          16'($urandom));
            else
                send_item(FN_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
        end
    endtask

    task automatic run_random(int n);
        int first;
        first = items_sent;
        while (items_sent - first < n) begin
            if ($urandom_range(0, 9) < 7)
                send_timer_sequence();
            else
                send_noise_item();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        send_item(FN_RD_MODE, 2'd3, '0);
        send_item(FN_RD_TARGET, 2'd3, COUNT_MAX);
        send_item(FN_RD_COUNT, 2'd0, '0);
        // timer 0: pixel clock, wraps at target 2, repeating interrupt
        send_item(FN_WR_MODE, 2'd0,
                  M_SRC_PIXEL | M_COUNT_TO_TARGET | M_IRQ_ON_TARGET | M_IRQ_REPEAT);
        send_item(FN_WR_TARGET, 2'd0, 16'd2);
        // timer 2: DIV8 source, one-shot interrupt at the top
        send_item(FN_WR_MODE, 2'd2, M_SRC_DIV8 | M_IRQ_ON_MAX);
        send_item(FN_WR_COUNT, 2'd2, COUNT_MAX);
        send_item(FN_WR_COUNT, 2'd2, COUNT_MAX);
        // timer 1: free running with its target at the top of the range
        send_item(FN_WR_MODE, 2'd1, M_IRQ_ON_TARGET | M_IRQ_REPEAT);
        send_item(FN_WR_TARGET, 2'd1, COUNT_MAX);
        send_item(FN_WR_COUNT, 2'd1, 16'hfffe);
        repeat (10) send_item(FN_TICK, 2'd0, '0);
        send_item(FN_RD_MODE, 2'd0, '0);
        send_item(FN_RD_COUNT, 2'd1, '0);
        send_item(FN_RD_MODE, 2'd2, '0);
        send_item(FN_WR_TARGET, 2'd3, '0);
        send_item(FN_WR_MODE, 2'd3, COUNT_MAX);
    endtask

    task automatic test_random_defaults();
        run_random(60);
        wait_for_replies();    // sender idles until everything is back
        run_random(60);
    endtask

    task automatic test_divider_extremes();
        set_dividers(DIV_MAX, 20'd1, DIV_MAX);
        send_item(FN_WR_MODE, 2'd0, M_SRC_PIXEL | M_IRQ_ON_MAX);
        send_item(FN_WR_MODE, 2'd1, M_SRC_PIXEL | M_IRQ_ON_TARGET | M_IRQ_REPEAT);
        send_item(FN_WR_TARGET, 2'd1, 16'd5);
        run_random(60);
        // let timer 3's phase grow, then shrink its divider beneath it
        repeat (40) send_item(FN_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
        wait_for_replies();
        write_divider(CFG_VBLANK, 20'd2);
        repeat (6) send_item(FN_TICK, 2'd0, '0);
        send_item(FN_RD_COUNT, 2'd3, '0);
        set_dividers(20'd1, DIV_MAX, 20'd1);
        run_random(60);
    endtask

    task automatic test_divider_sweep();
        repeat (4) begin
            set_dividers(20'($urandom_range(1, 6)), 20'($urandom_range(1, 12)),
                         20'($urandom_range(1, 40)));
            run_random(60);
        end
    endtask

    task automatic test_output_backpressure();
        long_hold_req = 1'b1;
        repeat (30) send_noise_item();
    endtask

    task automatic test_streaming();
        idle_bursts = 1'b0;
        run_random(120);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_func          <= FN_TICK;
        i_counter_index <= '0;
        i_value         <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        reset_timers();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_defaults();
        test_divider_extremes();
        test_divider_sweep();
        test_output_backpressure();
        test_streaming();
        wait_for_replies();

        $display("Sent %0d items (%0d ticks) across %0d divider register writes.",
                 items_sent, ticks_sent, cfg_writes);
        $display("Checked %0d results, %0d of them carrying interrupts; %0d mismatches.",
                 replies_checked, irq_replies, errors);
        if (errors == 0)
            $display("four_channel_root_counter_timer regression: pass");
        else
            $display("four_channel_root_counter_timer regression: fail");
        $finish;
    end

endmodule

>>> four_channel_root_counter_timer.f
src/fcrct_pkg.sv
src/four_channel_root_counter_timer.sv
verif/tb_top.sv
